FILE: rtl/bpcg_pkg.sv
// Shared types and constants for the banked PCG64 generator.
// Holds the word layouts, operation codes and LCG constants; no dependencies.
package bpcg_pkg;

    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_ADV  = 2'd1,
        OP_INIT = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_INIT  = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        MOP_STEP = 3'd0,
        MOP_AM   = 3'd1,
        MOP_AP   = 3'd2,
        MOP_CP   = 3'd3,
        MOP_CM   = 3'd4,
        MOP_FIN  = 3'd5
    } t_mop;

    typedef struct packed {
        t_op         opcode;
        logic [10:0] slice;
        logic [63:0] skip;
    } t_in;

    typedef struct packed {
        logic [63:0] fraction;
        logic        is_one;
        t_err        error;
    } t_out;

    typedef struct packed {
        logic latch;
        logic mem_rd;
        logic s_from_rd;
        logic s_from_seed;
        logic jump_init;
        logic use_gap;
        logic delta_shift;
        logic mul_start;
        t_mop mop;
        logic mem_wr;
        logic use_idx;
        logic idx_clr;
        logic idx_inc;
        logic cnt_load;
        logic res_load;
        logic res_draw;
        t_err err;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic oob;
        logic delta_zero;
        logic delta_lsb;
        logic mul_done;
        logic idx_last;
    } t_sts;

    localparam logic [127:0] LCG_MULT = {64'd2549297995355413924, 64'd4865540595714422341};
    localparam logic [127:0] LCG_INC  = {64'd6364136223846793005, 64'd1442695040888963407};

    localparam logic [3:0] PP_LAST = 4'd10;

    // Limb pairs {i, j} with i + j below four, in issue order.
    function automatic logic [3:0] pp_sel(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0:    r = {2'd0, 2'd0};
            4'd1:    r = {2'd0, 2'd1};
            4'd2:    r = {2'd1, 2'd0};
            4'd3:    r = {2'd0, 2'd2};
            4'd4:    r = {2'd1, 2'd1};
            4'd5:    r = {2'd2, 2'd0};
            4'd6:    r = {2'd0, 2'd3};
            4'd7:    r = {2'd1, 2'd2};
            4'd8:    r = {2'd2, 2'd1};
            4'd9:    r = {2'd3, 2'd0};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/bpcg_mul.sv
// Multi-cycle 128 by 128 bit multiply-add, product taken modulo 2^128.
// Uses one 32 by 32 bit multiplier over ten limb pairs; depends on bpcg_pkg.
module bpcg_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_x,
    input  logic [127:0] i_y,
    input  logic [127:0] i_z,
    output logic [127:0] o_p,
    output logic         o_done
);
    import bpcg_pkg::*;

    logic [127:0] r_x, r_y, r_acc;
    logic [63:0]  r_prod;
    logic [1:0]   r_sh;
    logic [3:0]   r_cnt;
    logic         r_busy, r_done;
    logic [3:0]   sel;
    logic [31:0]  a, b;

    always_comb begin
        sel = pp_sel(r_cnt);
        a   = r_x[{sel[3:2], 5'b0} +: 32];
        b   = r_y[{sel[1:0], 5'b0} +: 32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == PP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= i_z;
        end else if (r_busy) begin
            if (r_cnt != PP_LAST) begin
                r_prod <= 64'(a) * 64'(b);
                r_sh   <= 2'(sel[3:2] + sel[1:0]);
            end
            if (r_cnt != 4'd0) begin
                r_acc <= r_acc + (128'(r_prod) << {r_sh, 5'b0});
            end
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_done;

endmodule

FILE: rtl/bpcg_dp.sv
// Datapath: generator state memory, jump-ahead registers and result word.
// Instantiates bpcg_mul; depends on bpcg_pkg.
module bpcg_dp #(
    parameter int          MAX_SLICES = 1025,
    parameter logic [63:0] GAP        = 64'd33554432
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpcg_pkg::t_in  i_item,
    input  logic [63:0]    i_seed,
    input  logic [10:0]    i_slice_count,
    input  bpcg_pkg::t_cmd i_cmd,
    output bpcg_pkg::t_sts o_sts,
    output logic           o_valid,
    output bpcg_pkg::t_out o_result
);
    import bpcg_pkg::*;

    localparam int AW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int CW = $clog2(MAX_SLICES + 1);

    logic [127:0] r_mem [MAX_SLICES];
    logic [127:0] r_rd, r_s, r_am, r_ap, r_cm, r_cp;
    logic [63:0]  r_delta, r_skip;
    logic [AW-1:0] r_slice, r_idx, wr_addr;
    logic [CW-1:0] r_active;
    t_op          r_op;
    t_mop         r_mop;
    logic         r_valid;
    t_out         r_res;
    logic [127:0] mx, my, mz, mp;
    logic         mdone;
    logic [63:0]  xr, rr;

    bpcg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (mx),
        .i_y     (my),
        .i_z     (mz),
        .o_p     (mp),
        .o_done  (mdone)
    );

    always_comb begin
        mx = r_s;
        my = LCG_MULT;
        mz = LCG_INC;
        case (i_cmd.mop)
            MOP_AM: begin
                mx = r_am; my = r_cm; mz = '0;
            end
            MOP_AP: begin
                mx = r_ap; my = r_cm; mz = r_cp;
            end
            MOP_CP: begin
                mx = r_cm + 128'd1; my = r_cp; mz = '0;
            end
            MOP_CM: begin
                mx = r_cm; my = r_cm; mz = '0;
            end
            MOP_FIN: begin
                mx = r_am; my = r_s; mz = r_ap;
            end
            default: begin
                mx = r_s; my = LCG_MULT; mz = LCG_INC;
            end
        endcase
    end

    always_comb begin
        xr = r_s[127:64] ^ r_s[63:0];
        rr = 64'({xr, xr} >> r_s[127:122]);
        wr_addr = i_cmd.use_idx ? r_idx : r_slice;
        o_sts.op         = r_op;
        o_sts.oob        = 32'(i_item.slice) >= 32'(r_active);
        o_sts.delta_zero = (r_delta == 64'd0);
        o_sts.delta_lsb  = r_delta[0];
        o_sts.mul_done   = mdone;
        o_sts.idx_last   = (32'(r_idx) + 32'd1) >= 32'(r_active);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[AW'(i_item.slice)];
        end
        if (i_cmd.mem_wr) begin
            r_mem[wr_addr] <= r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CW'(1);
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_load;
            if (i_cmd.cnt_load) begin
                if (i_slice_count == 11'd0) begin
                    r_active <= CW'(1);
                end else if (32'(i_slice_count) > MAX_SLICES) begin
                    r_active <= CW'(MAX_SLICES);
                end else begin
                    r_active <= CW'(i_slice_count);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_item.opcode;
            r_slice <= AW'(i_item.slice);
            r_skip  <= i_item.skip;
        end
        if (i_cmd.mul_start) begin
            r_mop <= i_cmd.mop;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.s_from_seed) begin
            r_s <= {64'd0, i_seed} + LCG_INC;
        end else if (i_cmd.s_from_rd) begin
            r_s <= r_rd;
        end
        if (i_cmd.jump_init) begin
            r_am    <= 128'd1;
            r_ap    <= '0;
            r_cm    <= LCG_MULT;
            r_cp    <= LCG_INC;
            r_delta <= i_cmd.use_gap ? GAP : r_skip;
        end else if (i_cmd.delta_shift) begin
            r_delta <= r_delta >> 1;
        end
        if (mdone) begin
            case (r_mop)
                MOP_AM:  r_am <= mp;
                MOP_AP:  r_ap <= mp;
                MOP_CP:  r_cp <= mp;
                MOP_CM:  r_cm <= mp;
                default: r_s  <= mp;
            endcase
        end
        if (i_cmd.res_load) begin
            r_res.error <= i_cmd.err;
            if (i_cmd.res_draw) begin
                r_res.fraction <= rr + 64'd1;
                r_res.is_one   <= &rr;
            end else begin
                r_res.fraction <= '0;
                r_res.is_one   <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

FILE: rtl/bpcg_ctrl.sv
// Controller: sequences draws, jump-ahead loops and bank initialization.
// Drives the datapath through command and status words; depends on bpcg_pkg.
module bpcg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bpcg_pkg::t_op  i_op,
    input  bpcg_pkg::t_sts i_sts,
    output bpcg_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import bpcg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD,
        S_GO,
        S_JCHK,
        S_MWAIT,
        S_WR
    } t_state;

    t_state r_state, n_state;
    t_mop   r_mop;
    logic   r_ready, n_ready;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    unique case (i_op)
                        OP_INIT: begin
                            if (r_ready) begin
                                cmd.res_load = 1'b1;
                                cmd.err      = ERR_OK;
                            end else begin
                                cmd.cnt_load    = 1'b1;
                                cmd.s_from_seed = 1'b1;
                                cmd.idx_clr     = 1'b1;
                                n_state         = S_GO;
                            end
                        end
                        OP_DRAW, OP_ADV: begin
                            if (!r_ready) begin
                                cmd.res_load = 1'b1;
                                cmd.err      = ERR_INIT;
                            end else if (i_sts.oob) begin
                                cmd.res_load = 1'b1;
                                cmd.err      = ERR_RANGE;
                            end else begin
                                cmd.mem_rd = 1'b1;
                                n_state    = S_LD;
                            end
                        end
                        default: begin
                            cmd.res_load = 1'b1;
                            cmd.err      = ERR_OK;
                        end
                    endcase
                end
            end
            S_LD: begin
                cmd.s_from_rd = 1'b1;
                n_state       = S_GO;
            end
            S_GO: begin
                if (i_sts.op == OP_ADV) begin
                    cmd.jump_init = 1'b1;
                    n_state       = S_JCHK;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mop       = MOP_STEP;
                    n_state       = S_MWAIT;
                end
            end
            S_JCHK: begin
                cmd.mul_start = 1'b1;
                if (i_sts.delta_zero) begin
                    cmd.mop = MOP_FIN;
                end else if (i_sts.delta_lsb) begin
                    cmd.mop = MOP_AM;
                end else begin
                    cmd.mop = MOP_CP;
                end
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.mul_done) begin
                    case (r_mop)
                        MOP_AM: begin
                            cmd.mul_start = 1'b1;
                            cmd.mop       = MOP_AP;
                        end
                        MOP_AP: begin
                            cmd.mul_start = 1'b1;
                            cmd.mop       = MOP_CP;
                        end
                        MOP_CP: begin
                            cmd.mul_start = 1'b1;
                            cmd.mop       = MOP_CM;
                        end
                        MOP_CM: begin
                            cmd.delta_shift = 1'b1;
                            n_state         = S_JCHK;
                        end
                        default: n_state = S_WR;
                    endcase
                end
            end
            S_WR: begin
                cmd.mem_wr  = 1'b1;
                cmd.use_idx = (i_sts.op == OP_INIT);
                if (i_sts.op == OP_INIT) begin
                    if (i_sts.idx_last) begin
                        n_ready      = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.err      = ERR_OK;
                        n_state      = S_IDLE;
                    end else begin
                        cmd.idx_inc   = 1'b1;
                        cmd.jump_init = 1'b1;
                        cmd.use_gap   = 1'b1;
                        n_state       = S_JCHK;
                    end
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_draw = (i_sts.op == OP_DRAW);
                    cmd.err      = ERR_OK;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_mop   <= MOP_STEP;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            if (cmd.mul_start) begin
                r_mop <= cmd.mop;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> r_state == S_MWAIT)
        else $error("Multiplier finished outside the wait state.");
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |=> r_state == S_IDLE)
        else $error("Result issued without returning to idle.");
    a_ready_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("Bank ready flag dropped without reset.");
    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_start |=> !i_sts.mul_done)
        else $error("Multiplier reported done right after a start.");
`endif

endmodule

FILE: rtl/banked_pcg64_generator.sv
// Top level of the banked PCG64 generator: configuration registers and wiring.
// Depends on bpcg_pkg, bpcg_ctrl, bpcg_dp and bpcg_mul.
//
// A word is accepted on a rising edge with start high and busy low. Opcode
// draw steps one slice and returns its fraction, advance jumps a slice by skip
// steps, and init seeds the whole bank from the seed and slice_count registers.
// Every accepted word yields exactly one result word, shown on o_result for a
// single cycle with o_valid high; the receiver cannot stall it.
// Each 128-bit multiply runs on one shared 32 by 32 bit multiplier.
// An advance works through skip one bit at a time, squaring the step constants
// per bit and also updating the accumulated ones for each set bit. Init runs
// a jump by the slice gap between successive slices. Errors and ignored words
// return their result in the cycle after acceptance.
// Reset clears the bank ready flag and sets the active count to one; the
// state memory holds whatever it held until init writes it.
// Registers are written through the APB port: seed at 0x0, slice_count at 0x8.
module banked_pcg64_generator #(
    parameter int MAX_SLICES = 1025,
    parameter int SPACING    = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bpcg_pkg::t_in  i_item,
    output logic           o_valid,
    output bpcg_pkg::t_out o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);
    import bpcg_pkg::*;

    localparam logic [63:0] GAP = 64'd2 * 64'(SPACING) * 64'(SPACING);

    logic [63:0] r_seed;
    logic [10:0] r_slice_count;
    t_cmd        cmd;
    t_sts        sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= '0;
            r_slice_count <= 11'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[3]) begin
                r_slice_count <= pwdata[10:0];
            end else begin
                r_seed <= pwdata;
            end
        end
    end

    assign prdata = paddr[3] ? {53'd0, r_slice_count} : r_seed;
    assign pready = 1'b1;

    bpcg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.opcode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bpcg_dp #(
        .MAX_SLICES (MAX_SLICES),
        .GAP        (GAP)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_seed        (r_seed),
        .i_slice_count (r_slice_count),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

endmodule
